// ===== rtl/fjs_pkg.sv =====
// fjs_pkg: scan modes, character codes, record kinds and the record type
// for the flat JSON field scanner. No dependencies.
package fjs_pkg;

    typedef enum logic [3:0] {
        M_HDR0    = 4'd0,
        M_HDR1    = 4'd1,
        M_HEADKEY = 4'd2,
        M_MAIN    = 4'd3,
        M_VSKIP   = 4'd4,
        M_VOBJ    = 4'd5,
        M_VARR    = 4'd6,
        M_VOTHER  = 4'd7,
        M_KSKIP   = 4'd8,
        M_KEY     = 4'd9,
        M_DEAD    = 4'd10
    } t_mode;

    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_UP_T   = 8'h54;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_UP_F   = 8'h46;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    localparam logic [2:0] KIND_NUMBER  = 3'd0;
    localparam logic [2:0] KIND_BOOLEAN = 3'd1;
    localparam logic [2:0] KIND_STRING  = 3'd2;
    localparam logic [2:0] KIND_ARRAY   = 3'd3;
    localparam logic [2:0] KIND_OBJECT  = 3'd4;
    localparam logic [2:0] KIND_OTHER   = 3'd5;

    typedef struct packed {
        logic        is_value;
        logic [2:0]  kind;
        logic [15:0] start_pos;
        logic [15:0] end_pos;
        logic [15:0] record_index;
    } t_rec;

    function automatic logic [2:0] classify(input logic [7:0] c);
        logic [2:0] k;
        k = KIND_OTHER;
        if (c inside {[CH_ZERO:CH_NINE]}) begin
            k = KIND_NUMBER;
        end else if (c == CH_QUOTE) begin
            k = KIND_STRING;
        end else if (c == CH_LBRACK) begin
            k = KIND_ARRAY;
        end else if (c == CH_LBRACE) begin
            k = KIND_OBJECT;
        end else if (c inside {CH_LOW_T, CH_UP_T, CH_LOW_F, CH_UP_F}) begin
            k = KIND_BOOLEAN;
        end
        return k;
    endfunction

endpackage

// ===== rtl/fjs_step.sv =====
// fjs_step: next-state and record logic for one byte of the scanner.
// Purely combinational; uses fjs_pkg.
module fjs_step #(
    parameter int POSITION_BITS = 16
) (
    input  fjs_pkg::t_mode            i_mode,
    input  logic [POSITION_BITS-1:0]  i_pos,
    input  logic [POSITION_BITS-1:0]  i_span_start,
    input  logic [2:0]                i_span_kind,
    input  logic [15:0]               i_records,
    input  logic [7:0]                i_data,
    input  logic                      i_last,
    output fjs_pkg::t_mode            o_mode,
    output logic [POSITION_BITS-1:0]  o_pos,
    output logic [POSITION_BITS-1:0]  o_span_start,
    output logic [2:0]                o_span_kind,
    output logic [15:0]               o_records,
    output logic                      o_emit,
    output fjs_pkg::t_rec             o_rec
);

    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    fjs_pkg::t_mode           mode;
    logic [POSITION_BITS-1:0] span_start;
    logic [2:0]               span_kind;
    logic [POSITION_BITS-1:0] prev;
    logic [POSITION_BITS-1:0] rec_start;
    logic [POSITION_BITS-1:0] rec_end;
    logic [POSITION_BITS+15:0] start_ext;
    logic [POSITION_BITS+15:0] end_ext;
    logic                     emit;
    logic                     rec_is_value;
    logic [2:0]               rec_kind;
    fjs_pkg::t_mode           dispatch;

    assign prev = i_pos - POSITION_BITS'(1);

    always_comb begin
        if (i_data == fjs_pkg::CH_COLON) begin
            dispatch = fjs_pkg::M_VSKIP;
        end else if (i_data == fjs_pkg::CH_COMMA) begin
            dispatch = fjs_pkg::M_KSKIP;
        end else begin
            dispatch = fjs_pkg::M_MAIN;
        end
    end

    always_comb begin
        mode         = i_mode;
        span_start   = i_span_start;
        span_kind    = i_span_kind;
        emit         = 1'b0;
        rec_is_value = 1'b0;
        rec_kind     = fjs_pkg::KIND_STRING;
        rec_start    = i_span_start;
        rec_end      = i_pos;
        case (i_mode)
            fjs_pkg::M_HDR0: begin
                mode = (i_data == fjs_pkg::CH_LBRACE) ? fjs_pkg::M_HDR1 : fjs_pkg::M_DEAD;
            end
            fjs_pkg::M_HDR1: begin
                mode = (i_data == fjs_pkg::CH_QUOTE) ? fjs_pkg::M_HEADKEY : fjs_pkg::M_DEAD;
            end
            fjs_pkg::M_HEADKEY: begin
                if (i_data == fjs_pkg::CH_QUOTE) begin
                    emit      = 1'b1;
                    rec_start = POSITION_BITS'(1);
                    rec_end   = i_pos;
                    mode      = fjs_pkg::M_MAIN;
                end
            end
            fjs_pkg::M_MAIN: begin
                mode = dispatch;
            end
            fjs_pkg::M_VSKIP: begin
                if (i_data != fjs_pkg::CH_SPACE) begin
                    span_start = i_pos;
                    if (i_data == fjs_pkg::CH_LBRACE) begin
                        span_kind = fjs_pkg::KIND_OBJECT;
                        mode      = fjs_pkg::M_VOBJ;
                    end else if (i_data == fjs_pkg::CH_LBRACK) begin
                        span_kind = fjs_pkg::KIND_ARRAY;
                        mode      = fjs_pkg::M_VARR;
                    end else if (i_data == fjs_pkg::CH_COMMA ||
                                 i_data == fjs_pkg::CH_RBRACE) begin
                        // empty value
                        emit         = 1'b1;
                        rec_is_value = 1'b1;
                        rec_kind     = fjs_pkg::KIND_OTHER;
                        rec_start    = i_pos;
                        rec_end      = prev;
                        mode         = dispatch;
                    end else begin
                        span_kind = fjs_pkg::classify(i_data);
                        mode      = fjs_pkg::M_VOTHER;
                    end
                end
            end
            fjs_pkg::M_VOBJ: begin
                if (i_data == fjs_pkg::CH_RBRACE) begin
                    emit         = 1'b1;
                    rec_is_value = 1'b1;
                    rec_kind     = i_span_kind;
                    mode         = fjs_pkg::M_MAIN;
                end
            end
            fjs_pkg::M_VARR: begin
                if (i_data == fjs_pkg::CH_RBRACK) begin
                    emit         = 1'b1;
                    rec_is_value = 1'b1;
                    rec_kind     = i_span_kind;
                    mode         = fjs_pkg::M_MAIN;
                end
            end
            fjs_pkg::M_VOTHER: begin
                if (i_data == fjs_pkg::CH_COMMA || i_data == fjs_pkg::CH_RBRACE) begin
                    emit         = 1'b1;
                    rec_is_value = 1'b1;
                    rec_kind     = i_span_kind;
                    rec_end      = prev;
                    mode         = dispatch;
                end
            end
            fjs_pkg::M_KSKIP: begin
                if (i_data != fjs_pkg::CH_SPACE) begin
                    span_start = i_pos;
                    if (i_data == fjs_pkg::CH_COLON) begin
                        // empty key
                        emit      = 1'b1;
                        rec_start = i_pos;
                        rec_end   = prev;
                        mode      = dispatch;
                    end else begin
                        mode = fjs_pkg::M_KEY;
                    end
                end
            end
            fjs_pkg::M_KEY: begin
                if (i_data == fjs_pkg::CH_COLON) begin
                    emit    = 1'b1;
                    rec_end = prev;
                    mode    = dispatch;
                end
            end
            default: begin
                mode = fjs_pkg::M_DEAD;
            end
        endcase
    end

    assign start_ext = {16'd0, rec_start};
    assign end_ext   = {16'd0, rec_end};

    always_comb begin
        o_rec.is_value     = rec_is_value;
        o_rec.kind         = rec_kind;
        o_rec.start_pos    = start_ext[15:0];
        o_rec.end_pos      = end_ext[15:0];
        o_rec.record_index = i_records;
        o_emit             = emit;
        if (i_last) begin
            o_mode       = fjs_pkg::M_HDR0;
            o_pos        = '0;
            o_span_start = '0;
            o_span_kind  = fjs_pkg::KIND_NUMBER;
            o_records    = 16'd0;
        end else begin
            o_mode       = mode;
            o_pos        = (i_pos == POS_MAX) ? i_pos : i_pos + POSITION_BITS'(1);
            o_span_start = span_start;
            o_span_kind  = span_kind;
            o_records    = emit ? i_records + 16'd1 : i_records;
        end
    end

endmodule

// ===== rtl/flat_json_field_scanner.sv =====
// flat_json_field_scanner: top level; input register, scan state, record register.
// Depends on fjs_pkg and fjs_step.
//
//  channel | direction | handshake                 | payload
//  in      | request   | i_in_valid / o_in_stall   | i_data_byte, i_last_byte
//  out     | record    | o_out_valid / i_out_stall | o_is_value, o_kind, o_start_pos,
//          |           |                           | o_end_pos, o_record_index
//
// One byte per clock unless o_in_stall is high; records are registered.
// The scan state updates as a byte moves from the input register to the record register.
// Synchronous active-low reset clears scan state and both valid flags.
// o_in_stall rises only when both registers hold a request and the record is stalled.
module flat_json_field_scanner #(
    parameter int POSITION_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_is_value,
    output logic [2:0]  o_kind,
    output logic [15:0] o_start_pos,
    output logic [15:0] o_end_pos,
    output logic [15:0] o_record_index
);

    logic                     r_in_valid;
    logic [7:0]               r_data;
    logic                     r_last;
    fjs_pkg::t_mode           r_mode;
    logic [POSITION_BITS-1:0] r_pos;
    logic [POSITION_BITS-1:0] r_span_start;
    logic [2:0]               r_span_kind;
    logic [15:0]              r_records;
    logic                     r_out_valid;
    fjs_pkg::t_rec            r_rec;

    fjs_pkg::t_mode           n_mode;
    logic [POSITION_BITS-1:0] n_pos;
    logic [POSITION_BITS-1:0] n_span_start;
    logic [2:0]               n_span_kind;
    logic [15:0]              n_records;
    fjs_pkg::t_rec            n_rec;
    logic                     emit;

    logic out_ready;
    logic proc;
    logic in_take;

    assign out_ready  = !r_out_valid || !i_out_stall;
    assign proc       = r_in_valid && out_ready;
    assign o_in_stall = r_in_valid && !out_ready;
    assign in_take    = i_in_valid && !o_in_stall;

    fjs_step #(
        .POSITION_BITS(POSITION_BITS)
    ) u_step (
        .i_mode       (r_mode),
        .i_pos        (r_pos),
        .i_span_start (r_span_start),
        .i_span_kind  (r_span_kind),
        .i_records    (r_records),
        .i_data       (r_data),
        .i_last       (r_last),
        .o_mode       (n_mode),
        .o_pos        (n_pos),
        .o_span_start (n_span_start),
        .o_span_kind  (n_span_kind),
        .o_records    (n_records),
        .o_emit       (emit),
        .o_rec        (n_rec)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_mode       <= fjs_pkg::M_HDR0;
            r_pos        <= '0;
            r_span_start <= '0;
            r_span_kind  <= fjs_pkg::KIND_NUMBER;
            r_records    <= 16'd0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (proc) begin
                r_in_valid <= 1'b0;
            end
            if (proc) begin
                r_out_valid  <= emit;
                r_mode       <= n_mode;
                r_pos        <= n_pos;
                r_span_start <= n_span_start;
                r_span_kind  <= n_span_kind;
                r_records    <= n_records;
            end else if (out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_data <= i_data_byte;
            r_last <= i_last_byte;
        end
        if (proc && emit) begin
            r_rec <= n_rec;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_is_value     = r_rec.is_value;
    assign o_kind         = r_rec.kind;
    assign o_start_pos    = r_rec.start_pos;
    assign o_end_pos      = r_rec.end_pos;
    assign o_record_index = r_rec.record_index;

`ifndef ASSERT_OFF
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && r_last) |=> (r_pos == '0 && r_records == 16'd0 &&
                              r_mode == fjs_pkg::M_HDR0))
        else $error("state not cleared after last byte");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && emit && !r_last) |=> (r_records == $past(r_records) + 16'd1))
        else $error("record count did not advance");

    a_key_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_is_value) |-> (o_kind == fjs_pkg::KIND_STRING))
        else $error("key record with non-string kind");

    a_pos_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && !r_last) |=> (r_pos >= $past(r_pos)))
        else $error("byte position moved backward");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> r_out_valid)
        else $error("stalled record lost");
`endif

endmodule

// ===== dv/fjs_record_checker.sv =====
// fjs_record_checker: watches the byte and record channels of the flat JSON
// field scanner, predicts each record and compares it field by field.
// Depends on fjs_pkg for the scan modes, character codes, kinds and t_rec.
module fjs_record_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic        i_is_value,
    input  logic [2:0]  i_kind,
    input  logic [15:0] i_start_pos,
    input  logic [15:0] i_end_pos,
    input  logic [15:0] i_record_index,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [15:0] POS_LIMIT = 16'hFFFF;
    localparam int REPORT_LIMIT = 10;

    fjs_pkg::t_mode mode;
    logic [15:0]    byte_pos;
    logic [15:0]    span_start;
    logic [2:0]     span_kind;
    logic [15:0]    record_count;
    fjs_pkg::t_rec  expected_records[$];
    int             fail_count = 0;

    function automatic logic [2:0] kind_of(input logic [7:0] c);
        if (c >= fjs_pkg::CH_ZERO && c <= fjs_pkg::CH_NINE) return fjs_pkg::KIND_NUMBER;
        if (c == fjs_pkg::CH_QUOTE) return fjs_pkg::KIND_STRING;
        if (c == fjs_pkg::CH_LBRACK) return fjs_pkg::KIND_ARRAY;
        if (c == fjs_pkg::CH_LBRACE) return fjs_pkg::KIND_OBJECT;
        if (c == fjs_pkg::CH_LOW_T || c == fjs_pkg::CH_UP_T ||
            c == fjs_pkg::CH_LOW_F || c == fjs_pkg::CH_UP_F) begin
            return fjs_pkg::KIND_BOOLEAN;
        end
        return fjs_pkg::KIND_OTHER;
    endfunction

    // mode after a byte seen between spans
    function automatic fjs_pkg::t_mode mode_after(input logic [7:0] c);
        if (c == fjs_pkg::CH_COLON) return fjs_pkg::M_VSKIP;
        if (c == fjs_pkg::CH_COMMA) return fjs_pkg::M_KSKIP;
        return fjs_pkg::M_MAIN;
    endfunction

    task automatic add_record(input logic isv, input logic [2:0] k,
                              input logic [15:0] s, input logic [15:0] e);
        fjs_pkg::t_rec r;
        r.is_value     = isv;
        r.kind         = k;
        r.start_pos    = s;
        r.end_pos      = e;
        r.record_index = record_count;
        expected_records.push_back(r);
        record_count = record_count + 16'd1;
    endtask

    task automatic clear_scan();
        mode         = fjs_pkg::M_HDR0;
        byte_pos     = '0;
        span_start   = '0;
        span_kind    = fjs_pkg::KIND_NUMBER;
        record_count = '0;
    endtask

    task automatic scan_byte(input logic [7:0] c, input logic fin);
        logic [15:0] here;
        logic [15:0] prior;
        here  = byte_pos;
        prior = byte_pos - 16'd1;
        case (mode)
            fjs_pkg::M_HDR0: begin
                mode = (c == fjs_pkg::CH_LBRACE) ? fjs_pkg::M_HDR1 : fjs_pkg::M_DEAD;
            end
            fjs_pkg::M_HDR1: begin
                mode = (c == fjs_pkg::CH_QUOTE) ? fjs_pkg::M_HEADKEY : fjs_pkg::M_DEAD;
            end
            fjs_pkg::M_HEADKEY: begin
                if (c == fjs_pkg::CH_QUOTE) begin
                    add_record(1'b0, fjs_pkg::KIND_STRING, 16'd1, here);
                    mode = fjs_pkg::M_MAIN;
                end
            end
            fjs_pkg::M_MAIN: begin
                mode = mode_after(c);
            end
            fjs_pkg::M_VSKIP: begin
                if (c != fjs_pkg::CH_SPACE) begin
                    span_start = here;
                    if (c == fjs_pkg::CH_LBRACE) begin
                        span_kind = fjs_pkg::KIND_OBJECT;
                        mode = fjs_pkg::M_VOBJ;
                    end else if (c == fjs_pkg::CH_LBRACK) begin
                        span_kind = fjs_pkg::KIND_ARRAY;
                        mode = fjs_pkg::M_VARR;
                    end else if (c == fjs_pkg::CH_COMMA || c == fjs_pkg::CH_RBRACE) begin
                        add_record(1'b1, fjs_pkg::KIND_OTHER, here, prior);
                        mode = mode_after(c);
                    end else begin
                        span_kind = kind_of(c);
                        mode = fjs_pkg::M_VOTHER;
                    end
                end
            end
            fjs_pkg::M_VOBJ: begin
                if (c == fjs_pkg::CH_RBRACE) begin
                    add_record(1'b1, span_kind, span_start, here);
                    mode = fjs_pkg::M_MAIN;
                end
            end
            fjs_pkg::M_VARR: begin
                if (c == fjs_pkg::CH_RBRACK) begin
                    add_record(1'b1, span_kind, span_start, here);
                    mode = fjs_pkg::M_MAIN;
                end
            end
            fjs_pkg::M_VOTHER: begin
                if (c == fjs_pkg::CH_COMMA || c == fjs_pkg::CH_RBRACE) begin
                    add_record(1'b1, span_kind, span_start, prior);
                    mode = mode_after(c);
                end
            end
            fjs_pkg::M_KSKIP: begin
                if (c != fjs_pkg::CH_SPACE) begin
                    span_start = here;
                    if (c == fjs_pkg::CH_COLON) begin
                        add_record(1'b0, fjs_pkg::KIND_STRING, here, prior);
                        mode = mode_after(c);
                    end else begin
                        mode = fjs_pkg::M_KEY;
                    end
                end
            end
            fjs_pkg::M_KEY: begin
                if (c == fjs_pkg::CH_COLON) begin
                    add_record(1'b0, fjs_pkg::KIND_STRING, span_start, prior);
                    mode = mode_after(c);
                end
            end
            default: begin
                mode = fjs_pkg::M_DEAD;
            end
        endcase
        if (byte_pos != POS_LIMIT) byte_pos = byte_pos + 16'd1;
        if (fin) clear_scan();
    endtask

    task automatic check_record();
        fjs_pkg::t_rec want;
        if (expected_records.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT) begin
                $display("unexpected record: isv=%0d kind=%0d start=%0d end=%0d idx=%0d",
                         i_is_value, i_kind, i_start_pos, i_end_pos, i_record_index);
            end
        end else begin
            want = expected_records.pop_front();
            if (i_is_value !== want.is_value || i_kind !== want.kind ||
                i_start_pos !== want.start_pos || i_end_pos !== want.end_pos ||
                i_record_index !== want.record_index) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT) begin
                    $display("mismatch exp: isv=%0d kind=%0d start=%0d end=%0d idx=%0d",
                             want.is_value, want.kind, want.start_pos, want.end_pos,
                             want.record_index);
                    $display("         got: isv=%0d kind=%0d start=%0d end=%0d idx=%0d",
                             i_is_value, i_kind, i_start_pos, i_end_pos, i_record_index);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_scan();
            expected_records.delete();
        end else begin
            if (i_out_valid && !i_out_stall) check_record();
            if (i_in_valid && !i_in_stall) scan_byte(i_data_byte, i_last_byte);
        end
        o_fail_count = fail_count;
        o_pending    = expected_records.size();
    end

endmodule

// ===== dv/tb_top.sv =====
// tb_top: drives JSON documents into flat_json_field_scanner with and without random
// sender gaps and record stalls; fjs_record_checker predicts and compares.
// Depends on fjs_pkg, flat_json_field_scanner and fjs_record_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 10;

    typedef enum int {
        V_NUMBER, V_BOOL, V_STRING, V_ARRAY, V_OBJECT, V_OTHER, V_EMPTY
    } t_shape;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_last_byte = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_is_value;
    logic [2:0]  o_kind;
    logic [15:0] o_start_pos;
    logic [15:0] o_end_pos;
    logic [15:0] o_record_index;

    int fail_count;
    int pending_records;
    int send_gap_pct = 0;
    int recv_stall_pct = 0;
    int bytes_sent = 0;
    int idle_cycles = 0;

    logic [7:0] doc_q[$];
    string      word_pool = "abcxyz0189_-.";

    flat_json_field_scanner i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_data_byte    (i_data_byte),
        .i_last_byte    (i_last_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_is_value     (o_is_value),
        .o_kind         (o_kind),
        .o_start_pos    (o_start_pos),
        .o_end_pos      (o_end_pos),
        .o_record_index (o_record_index)
    );

    fjs_record_checker i_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_data_byte    (i_data_byte),
        .i_last_byte    (i_last_byte),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_is_value     (o_is_value),
        .i_kind         (o_kind),
        .i_start_pos    (o_start_pos),
        .i_end_pos      (o_end_pos),
        .i_record_index (o_record_index),
        .o_fail_count   (fail_count),
        .o_pending      (pending_records)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic fin);
        while ($urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= fin;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_doc(input int cut);
        for (int k = 0; k < cut; k++) send_byte(doc_q[k], k == cut - 1);
    endtask

    task automatic push_text(input string s);
        for (int k = 0; k < s.len(); k++) doc_q.push_back(s[k]);
    endtask

    task automatic push_spaces(input int n);
        repeat (n) doc_q.push_back(fjs_pkg::CH_SPACE);
    endtask

    task automatic push_word(input int n);
        repeat (n) doc_q.push_back(word_pool[$urandom_range(word_pool.len() - 1)]);
    endtask

    task automatic push_digits(input int n);
        repeat (n) doc_q.push_back(fjs_pkg::CH_ZERO + 8'($urandom_range(9)));
    endtask

    task automatic push_value();
        t_shape shape;
        push_spaces($urandom_range(2));
        shape = t_shape'($urandom_range(6));
        case (shape)
            V_NUMBER: begin
                push_digits($urandom_range(1, 4));
            end
            V_BOOL: begin
                case ($urandom_range(3))
                    0: push_text("true");
                    1: push_text("false");
                    2: push_text("T");
                    default: push_text("False");
                endcase
            end
            V_STRING: begin
                doc_q.push_back(fjs_pkg::CH_QUOTE);
                push_word($urandom_range(4));
                doc_q.push_back(fjs_pkg::CH_QUOTE);
            end
            V_ARRAY: begin
                doc_q.push_back(fjs_pkg::CH_LBRACK);
                if ($urandom_range(1)) begin
                    push_digits($urandom_range(1, 2));
                    doc_q.push_back(fjs_pkg::CH_COMMA);
                    push_digits(1);
                end
                doc_q.push_back(fjs_pkg::CH_RBRACK);
            end
            V_OBJECT: begin
                push_text("{\"a\":");
                push_digits(1);
                doc_q.push_back(fjs_pkg::CH_RBRACE);
            end
            V_OTHER: begin
                if ($urandom_range(1)) push_text("null");
                else push_text("-5.");
            end
            default: begin
            end
        endcase
        push_spaces($urandom_range(1));
    endtask

    task automatic push_key();
        push_spaces($urandom_range(1));
        case ($urandom_range(2))
            0: begin
                doc_q.push_back(fjs_pkg::CH_QUOTE);
                push_word($urandom_range(4));
                doc_q.push_back(fjs_pkg::CH_QUOTE);
            end
            1: push_word($urandom_range(1, 3));
            default: begin
            end
        endcase
        push_spaces($urandom_range(1));
    endtask

    task automatic random_document();
        int         pick;
        int         cut;
        logic [7:0] b;
        doc_q = {};
        pick = $urandom_range(99);
        if (pick < 78) begin
            doc_q.push_back(fjs_pkg::CH_LBRACE);
            doc_q.push_back(fjs_pkg::CH_QUOTE);
            push_word($urandom_range(4));
            doc_q.push_back(fjs_pkg::CH_QUOTE);
            if ($urandom_range(7) != 0) begin
                doc_q.push_back(fjs_pkg::CH_COLON);
                push_value();
            end
            repeat ($urandom_range(4)) begin
                doc_q.push_back(fjs_pkg::CH_COMMA);
                push_key();
                doc_q.push_back(fjs_pkg::CH_COLON);
                push_value();
            end
            doc_q.push_back(fjs_pkg::CH_RBRACE);
            if ($urandom_range(4) == 0) push_spaces($urandom_range(1, 2));
            if ($urandom_range(9) == 0) begin
                doc_q[$urandom_range(doc_q.size() - 1)] = 8'($urandom_range(255));
            end
        end else if (pick < 88) begin
            // broken header
            if ($urandom_range(1)) begin
                doc_q.push_back(fjs_pkg::CH_LBRACE);
                b = 8'($urandom_range(255));
                doc_q.push_back((b == fjs_pkg::CH_QUOTE) ? 8'h00 : b);
            end else begin
                b = 8'($urandom_range(255));
                doc_q.push_back((b == fjs_pkg::CH_LBRACE) ? fjs_pkg::CH_LBRACK : b);
            end
            push_text("\"a\":1,");
            repeat ($urandom_range(4)) doc_q.push_back(8'($urandom_range(255)));
        end else begin
            repeat ($urandom_range(1, 16)) doc_q.push_back(8'($urandom_range(255)));
        end
        cut = doc_q.size();
        if ($urandom_range(9) == 0) cut = $urandom_range(1, doc_q.size());
        send_doc(cut);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_gap_pct   = 22;
        recv_stall_pct = 86;

        doc_q = {};
        push_text("{\"\":{},:[]}");
        send_doc(doc_q.size());
        doc_q = {};
        push_text("{\"q\": ,f}");
        send_doc(doc_q.size());
        doc_q = {};
        push_text("[x");
        send_doc(doc_q.size());
        doc_q = {};
        push_text("{\"\":t");
        doc_q.push_back(8'h00);
        doc_q.push_back(8'hFF);
        doc_q.push_back(fjs_pkg::CH_RBRACE);
        send_doc(doc_q.size());

        while (bytes_sent < 650) random_document();
        send_gap_pct   = 86;
        recv_stall_pct = 22;
        while (bytes_sent < 1300) random_document();
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        while (bytes_sent < 1950) random_document();
        i_in_valid <= 1'b0;

        while (pending_records != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_records == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
